@@ rtl/ucfp_pkg.sv @@
// ucfp_pkg: shared types and constants for the uart command frame parser
// holds the byte token format passed from front to back and the queue sizing
// no dependencies

package ucfp_pkg;

    // longest frame in bytes, counting the start byte and the newline
    localparam int MAX_FRAME = 200;
    // frame length counter saturates at MAX_FRAME + 1
    localparam int LEN_W     = $clog2(MAX_FRAME + 2);

    // token queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // byte classes seen by the frame engine
    typedef enum logic [3:0] {
        TK_SPEED,
        TK_MONITOR,
        TK_MANUAL,
        TK_STAR,
        TK_F,
        TK_COMMA,
        TK_NL,
        TK_SPACE,
        TK_PLUS,
        TK_MINUS,
        TK_DIGIT,
        TK_OTHER
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
    } token_t;

endpackage

@@ rtl/uart_command_frame_parser.sv @@
// uart_command_frame_parser: top level; front classifier, token queue and frame engine
// depends on ucfp_pkg, ucfp_front, ucfp_queue, ucfp_back
//
//  channel | ports                                  | role
//  --------+----------------------------------------+------------------------------
//  in      | s_valid s_ready s_rx_byte              | one uart byte per item
//  out     | m_valid m_ready m_frame_kind m_status  | one result item per frame
//          | m_right_order m_left_order             |
//          | m_verbose_level                        |
//  cfg     | cfg_wr_en cfg_wr_data                  | order limit, written at once
//
// one byte per cycle sustained unless the queue is full; bytes are registered in the queue
// ahead of the frame engine; a frame's result is registered when its newline is processed
// the four-entry token queue lets input keep flowing while a result waits on m_ready
// a newline token waits in the queue only while the output register is still full
// reset (aresetn low, synchronous) empties the queue, returns to hunting for a start
// byte, zeroes the held orders and sets the order limit to 255

module uart_command_frame_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_frame_kind,
    output logic [2:0]        m_status,
    output logic signed [8:0] m_right_order,
    output logic signed [8:0] m_left_order,
    output logic [1:0]        m_verbose_level
);
    import ucfp_pkg::*;

    logic   q_full;
    logic   q_push;
    token_t q_push_tok;
    logic   q_pop;
    logic   q_valid;
    token_t q_tok;

    // byte intake and classification
    ucfp_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_rx_byte(s_rx_byte),
        .q_full   (q_full),
        .push     (q_push),
        .push_tok (q_push_tok)
    );

    // token queue
    ucfp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_tok (q_push_tok),
        .full     (q_full),
        .pop      (q_pop),
        .pop_valid(q_valid),
        .pop_tok  (q_tok)
    );

    // frame engine and result register
    ucfp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .q_valid        (q_valid),
        .q_tok          (q_tok),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_kind   (m_frame_kind),
        .m_status       (m_status),
        .m_right_order  (m_right_order),
        .m_left_order   (m_left_order),
        .m_verbose_level(m_verbose_level)
    );

endmodule

@@ rtl/ucfp_front.sv @@
// ucfp_front: accepts uart bytes, drops zero bytes and classifies the rest
// into tokens for the frame engine
// depends on ucfp_pkg

module ucfp_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    input  logic                  q_full,
    output logic                  push,
    output ucfp_pkg::token_t      push_tok
);
    import ucfp_pkg::*;

    localparam logic [7:0] CH_SPEED   = 8'h24;
    localparam logic [7:0] CH_MONITOR = 8'h26;
    localparam logic [7:0] CH_MANUAL  = 8'h23;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    assign s_ready   = !q_full;

    // zero bytes are taken but never queued
    assign push = s_valid && !q_full && (s_rx_byte != 8'h00);

    // byte classification
    always_comb begin
        // low nibble holds the digit value for '0' to '9'
        push_tok.digit = s_rx_byte[3:0];
        if (s_rx_byte == CH_SPEED) begin
            push_tok.kind = TK_SPEED;
        end else if (s_rx_byte == CH_MONITOR) begin
            push_tok.kind = TK_MONITOR;
        end else if (s_rx_byte == CH_MANUAL) begin
            push_tok.kind = TK_MANUAL;
        end else if (s_rx_byte == CH_STAR) begin
            push_tok.kind = TK_STAR;
        end else if (s_rx_byte == CH_F) begin
            push_tok.kind = TK_F;
        end else if (s_rx_byte == CH_COMMA) begin
            push_tok.kind = TK_COMMA;
        end else if (s_rx_byte == CH_NL) begin
            push_tok.kind = TK_NL;
        end else if (s_rx_byte == CH_SP || (s_rx_byte >= CH_TAB && s_rx_byte <= CH_CR)) begin
            push_tok.kind = TK_SPACE;
        end else if (s_rx_byte == CH_PLUS) begin
            push_tok.kind = TK_PLUS;
        end else if (s_rx_byte == CH_MINUS) begin
            push_tok.kind = TK_MINUS;
        end else if (s_rx_byte >= CH_ZERO && s_rx_byte <= CH_NINE) begin
            push_tok.kind = TK_DIGIT;
        end else begin
            push_tok.kind = TK_OTHER;
        end
    end

endmodule

@@ rtl/ucfp_queue.sv @@
// ucfp_queue: short token fifo that decouples the front from the frame engine
// depends on ucfp_pkg

module ucfp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ucfp_pkg::token_t  push_tok,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output ucfp_pkg::token_t  pop_tok
);
    import ucfp_pkg::*;

    token_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_tok   = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

@@ rtl/ucfp_back.sv @@
// ucfp_back: frame engine; tracks the open frame, checksum and both numbers,
// and builds one result item per completed frame into an output register
// depends on ucfp_pkg

module ucfp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              q_valid,
    input  ucfp_pkg::token_t  q_tok,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_frame_kind,
    output logic [2:0]        m_status,
    output logic signed [8:0] m_right_order,
    output logic signed [8:0] m_left_order,
    output logic [1:0]        m_verbose_level
);
    import ucfp_pkg::*;

    localparam logic [1:0] KIND_SPEED   = 2'd0;
    localparam logic [1:0] KIND_MONITOR = 2'd1;
    localparam logic [1:0] KIND_MANUAL  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SUM  = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_NO_COMMA = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    localparam logic [11:0] MAG_SAT = 12'd255;

    typedef enum logic [1:0] {FT_HUNT, FT_SPEED, FT_MONITOR, FT_MANUAL} frame_type_t;
    typedef enum logic [2:0] {CK_NONE, CK_STAR, CK_F1, CK_F2, CK_BAD} check_t;
    typedef enum logic [2:0] {
        PH_WS, PH_PLUS, PH_MINUS, PH_DPOS, PH_DNEG, PH_ENDPOS, PH_ENDNEG, PH_IDLE
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] mag;
    } num_t;

    // atoi-style number tracker, one token per call
    function automatic num_t feed_number(num_t cur, token_t tok);
        num_t        res;
        logic [11:0] acc;
        logic        digit;
        begin
            res   = cur;
            digit = (tok.kind == TK_DIGIT);
            acc   = 12'(cur.mag) * 12'd10 + 12'(tok.digit);
            case (cur.phase)
                PH_WS: begin
                    if (tok.kind == TK_SPACE) begin
                        res.phase = PH_WS;
                    end else if (tok.kind == TK_PLUS) begin
                        res.phase = PH_PLUS;
                    end else if (tok.kind == TK_MINUS) begin
                        res.phase = PH_MINUS;
                    end else if (digit) begin
                        res.phase = PH_DPOS;
                        res.mag   = 8'(tok.digit);
                    end else begin
                        res.phase = PH_ENDPOS;
                    end
                end
                PH_PLUS, PH_MINUS: begin
                    if (digit) begin
                        res.phase = (cur.phase == PH_PLUS) ? PH_DPOS : PH_DNEG;
                        res.mag   = 8'(tok.digit);
                    end else begin
                        res.phase = (cur.phase == PH_PLUS) ? PH_ENDPOS : PH_ENDNEG;
                    end
                end
                PH_DPOS, PH_DNEG: begin
                    if (digit) begin
                        res.mag = (acc > MAG_SAT) ? 8'hFF : acc[7:0];
                    end else begin
                        res.phase = (cur.phase == PH_DPOS) ? PH_ENDPOS : PH_ENDNEG;
                    end
                end
                default: begin
                    res = cur;
                end
            endcase
            return res;
        end
    endfunction

    function automatic logic is_neg(phase_t ph);
        return ph == PH_MINUS || ph == PH_DNEG || ph == PH_ENDNEG;
    endfunction

    function automatic logic signed [8:0] signed_of(num_t n);
        logic signed [8:0] pos;
        begin
            pos = $signed({1'b0, n.mag});
            return is_neg(n.phase) ? -pos : pos;
        end
    endfunction

    // state
    logic [7:0]        limit_reg;
    frame_type_t       ft_reg, ft_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    check_t            ck_reg, ck_next;
    logic              comma_reg, comma_next;
    num_t              first_reg, first_next;
    num_t              second_reg, second_next;
    logic signed [8:0] right_reg, right_next;
    logic signed [8:0] left_reg, left_next;
    logic              m_valid_reg;
    logic [1:0]        kind_reg, kind_next;
    logic [2:0]        status_reg, status_next;
    logic signed [8:0] out_right_reg;
    logic signed [8:0] out_left_reg;
    logic [1:0]        level_reg, level_next;

    logic              out_free;
    logic              take;
    logic              out_load;
    logic              ck_ok;
    num_t              first_fed;
    num_t              second_fed;
    num_t              fresh_num;
    num_t              idle_num;

    assign out_free  = !m_valid_reg || m_ready;
    assign take      = q_valid && (ft_reg == FT_HUNT || q_tok.kind != TK_NL || out_free);
    assign q_pop     = take;
    assign ck_ok     = (ck_reg == CK_F2);
    assign first_fed  = feed_number(first_reg, q_tok);
    assign second_fed = feed_number(second_reg, q_tok);
    assign fresh_num  = '{phase: PH_WS, mag: 8'd0};
    assign idle_num   = '{phase: PH_IDLE, mag: 8'd0};

    assign m_valid         = m_valid_reg;
    assign m_frame_kind    = kind_reg;
    assign m_status        = status_reg;
    assign m_right_order   = out_right_reg;
    assign m_left_order    = out_left_reg;
    assign m_verbose_level = level_reg;

    // per-token frame update
    always_comb begin
        ft_next     = ft_reg;
        len_next    = len_reg;
        ck_next     = ck_reg;
        comma_next  = comma_reg;
        first_next  = first_reg;
        second_next = second_reg;
        right_next  = right_reg;
        left_next   = left_reg;
        kind_next   = kind_reg;
        status_next = ST_OK;
        level_next  = 2'd0;
        out_load    = 1'b0;

        if (take) begin
            if (ft_reg == FT_HUNT) begin
                // hunt for a start byte
                if (q_tok.kind == TK_SPEED || q_tok.kind == TK_MONITOR ||
                    q_tok.kind == TK_MANUAL) begin
                    case (q_tok.kind)
                        TK_SPEED:   ft_next = FT_SPEED;
                        TK_MONITOR: ft_next = FT_MONITOR;
                        default:    ft_next = FT_MANUAL;
                    endcase
                    len_next    = LEN_W'(1);
                    ck_next     = CK_NONE;
                    comma_next  = 1'b0;
                    first_next  = fresh_num;
                    second_next = idle_num;
                end
            end else if (q_tok.kind != TK_NL) begin
                // frame body
                if (len_reg <= LEN_W'(MAX_FRAME)) begin
                    len_next = len_reg + 1'b1;
                end
                case (ck_reg)
                    CK_NONE: ck_next = (q_tok.kind == TK_STAR) ? CK_STAR : CK_NONE;
                    CK_STAR: ck_next = (q_tok.kind == TK_F) ? CK_F1 : CK_BAD;
                    CK_F1:   ck_next = (q_tok.kind == TK_F) ? CK_F2 : CK_BAD;
                    CK_F2:   ck_next = CK_BAD;
                    default: ck_next = CK_BAD;
                endcase
                if (q_tok.kind == TK_COMMA) begin
                    comma_next = 1'b1;
                end
                first_next = first_fed;
                if (second_reg.phase == PH_IDLE) begin
                    if (q_tok.kind == TK_COMMA) begin
                        second_next = fresh_num;
                    end
                end else begin
                    second_next = second_fed;
                end
            end else begin
                // newline closes the frame
                out_load = 1'b1;
                case (ft_reg)
                    FT_SPEED:   kind_next = KIND_SPEED;
                    FT_MONITOR: kind_next = KIND_MONITOR;
                    default:    kind_next = KIND_MANUAL;
                endcase
                if (len_reg >= LEN_W'(MAX_FRAME)) begin
                    // this newline pushes the count past the limit
                    status_next = ST_TOO_LONG;
                end else if (ft_reg == FT_SPEED) begin
                    if (!comma_reg) begin
                        status_next = ST_NO_COMMA;
                    end else if (!ck_ok) begin
                        status_next = ST_BAD_SUM;
                        right_next  = '0;
                        left_next   = '0;
                    end else if (first_reg.mag >= limit_reg ||
                                 second_reg.mag >= limit_reg) begin
                        status_next = ST_RANGE;
                        right_next  = '0;
                        left_next   = '0;
                    end else begin
                        right_next = signed_of(first_reg);
                        left_next  = signed_of(second_reg);
                    end
                end else if (ft_reg == FT_MONITOR) begin
                    if (!ck_ok) begin
                        status_next = ST_BAD_SUM;
                    end else if (!is_neg(first_reg.phase) && first_reg.mag <= 8'd3) begin
                        level_next = first_reg.mag[1:0];
                    end
                end else begin
                    if (!comma_reg) begin
                        status_next = ST_NO_COMMA;
                    end else if (!ck_ok) begin
                        status_next = ST_BAD_SUM;
                    end
                end
                ft_next     = FT_HUNT;
                len_next    = '0;
                ck_next     = CK_NONE;
                comma_next  = 1'b0;
                first_next  = fresh_num;
                second_next = idle_num;
            end
        end
    end

    // frame state, held orders and limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= 8'd255;
            ft_reg      <= FT_HUNT;
            len_reg     <= '0;
            ck_reg      <= CK_NONE;
            comma_reg   <= 1'b0;
            first_reg   <= '{phase: PH_WS, mag: 8'd0};
            second_reg  <= '{phase: PH_IDLE, mag: 8'd0};
            right_reg   <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            ft_reg     <= ft_next;
            len_reg    <= len_next;
            ck_reg     <= ck_next;
            comma_reg  <= comma_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            right_reg  <= right_next;
            left_reg   <= left_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            kind_reg      <= kind_next;
            status_reg    <= status_next;
            out_right_reg <= right_next;
            out_left_reg  <= left_next;
            level_reg     <= level_next;
        end
    end

    // a result appears only after a newline closed an open frame
    a_result_from_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(take && q_tok.kind == TK_NL && ft_reg != FT_HUNT))
        else $error("result without a closing newline");

    // an accepted speed frame stays inside the limit
    a_speed_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && ft_reg == FT_SPEED && status_next == ST_OK |->
            first_reg.mag < limit_reg && second_reg.mag < limit_reg)
        else $error("accepted speed order beyond the limit");

    // verbose level only on monitor frames
    a_level_monitor_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && level_reg != 2'd0 |-> kind_reg == KIND_MONITOR && status_reg == ST_OK)
        else $error("verbose level on a non-monitor result");

    // length counter never passes its saturation point
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_FRAME + 1) && (ft_reg != FT_HUNT || len_reg == '0))
        else $error("frame length counter out of range");

endmodule

@@ tb/sv/uart_command_frame_parser_tb.sv @@
// uart_command_frame_parser_tb: self-checking bench for the uart command frame parser
// a scoreboard class predicts one result per frame from the accepted bytes
// depends on ucfp_pkg and uart_command_frame_parser
`timescale 1ns / 1ps

module uart_command_frame_parser_tb;

    // byte values the frame engine reacts to
    localparam logic [7:0] B_SPEED   = 8'h24;
    localparam logic [7:0] B_MONITOR = 8'h26;
    localparam logic [7:0] B_MANUAL  = 8'h23;
    localparam logic [7:0] B_STAR    = 8'h2A;
    localparam logic [7:0] B_COMMA   = 8'h2C;
    localparam logic [7:0] B_NL      = 8'h0A;
    localparam logic [7:0] B_F       = 8'h46;
    localparam logic [7:0] B_PLUS    = 8'h2B;
    localparam logic [7:0] B_MINUS   = 8'h2D;
    localparam logic [7:0] B_SPACE   = 8'h20;
    localparam logic [7:0] B_TAB     = 8'h09;
    localparam logic [7:0] B_CR      = 8'h0D;
    localparam logic [7:0] B_DIGIT0  = 8'h30;
    localparam logic [7:0] B_DIGIT9  = 8'h39;
    localparam int unsigned MAG_CAP  = 255;
    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef enum logic [1:0] {FT_HUNT, FT_SPEED, FT_MONITOR, FT_MANUAL} frame_type_t;
    typedef enum logic [1:0] {KIND_SPEED, KIND_MONITOR, KIND_MANUAL} frame_kind_t;
    typedef enum logic [2:0] {
        ST_OK, ST_BAD_CHECK, ST_RANGE, ST_NO_COMMA, ST_TOO_LONG
    } frame_status_t;
    typedef enum logic [2:0] {CK_NONE, CK_STAR, CK_F1, CK_F2, CK_BAD} check_state_t;
    typedef enum logic [2:0] {
        NP_WS, NP_PLUS, NP_MINUS, NP_DPOS, NP_DNEG, NP_ENDPOS, NP_ENDNEG, NP_IDLE
    } num_phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] status;
        logic [8:0] right_order;
        logic [8:0] left_order;
        logic [1:0] level;
    } frame_result_t;

    // frame predictor and result checker
    class frame_scoreboard;
        logic [7:0]    order_limit;
        frame_type_t   ftype;
        int unsigned   flen;
        check_state_t  ck;
        bit            comma_seen;
        int unsigned   a_mag;
        int unsigned   b_mag;
        num_phase_t    a_phase;
        num_phase_t    b_phase;
        int            right_held;
        int            left_held;
        frame_result_t expected_frames[$];
        int unsigned   predicted_total;
        int unsigned   fail_count;

        function new();
            order_limit     = 8'd255;
            right_held      = 0;
            left_held       = 0;
            predicted_total = 0;
            fail_count      = 0;
            open_frame(FT_HUNT);
            flen = 0;
        endfunction

        function void open_frame(frame_type_t t);
            ftype      = t;
            flen       = 1;
            ck         = CK_NONE;
            comma_seen = 1'b0;
            a_mag      = 0;
            a_phase    = NP_WS;
            b_mag      = 0;
            b_phase    = NP_IDLE;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == B_SPACE || (c >= B_TAB && c <= B_CR);
        endfunction

        // atoi style reader: whitespace, one sign, digits saturating at 255
        function void step_number(inout num_phase_t ph, inout int unsigned mag,
                                  input logic [7:0] c);
            bit          digit;
            int unsigned d;
            int unsigned v;
            digit = (c >= B_DIGIT0 && c <= B_DIGIT9);
            d = {24'd0, c - B_DIGIT0};
            case (ph)
                NP_WS: begin
                    if (!is_blank(c)) begin
                        if (c == B_PLUS) ph = NP_PLUS;
                        else if (c == B_MINUS) ph = NP_MINUS;
                        else if (digit) begin
                            ph  = NP_DPOS;
                            mag = d;
                        end else ph = NP_ENDPOS;
                    end
                end
                NP_PLUS, NP_MINUS: begin
                    if (digit) begin
                        ph  = (ph == NP_PLUS) ? NP_DPOS : NP_DNEG;
                        mag = d;
                    end else ph = (ph == NP_PLUS) ? NP_ENDPOS : NP_ENDNEG;
                end
                NP_DPOS, NP_DNEG: begin
                    if (digit) begin
                        v   = mag * 10 + d;
                        mag = (v > MAG_CAP) ? MAG_CAP : v;
                    end else ph = (ph == NP_DPOS) ? NP_ENDPOS : NP_ENDNEG;
                end
                default: ;
            endcase
        endfunction

        function int signed_order(num_phase_t ph, int unsigned mag);
            if (ph == NP_MINUS || ph == NP_DNEG || ph == NP_ENDNEG) return -int'(mag);
            return int'(mag);
        endfunction

        // one accepted byte; a newline inside a frame yields one expected result
        function void note_byte(logic [7:0] c);
            frame_result_t res;
            bit            ck_ok;
            int            v;
            if (c == 8'h00) return;
            if (ftype == FT_HUNT) begin
                if (c == B_SPEED) open_frame(FT_SPEED);
                else if (c == B_MONITOR) open_frame(FT_MONITOR);
                else if (c == B_MANUAL) open_frame(FT_MANUAL);
                return;
            end
            if (flen <= ucfp_pkg::MAX_FRAME) flen++;
            if (c != B_NL) begin
                case (ck)
                    CK_NONE: if (c == B_STAR) ck = CK_STAR;
                    CK_STAR: ck = (c == B_F) ? CK_F1 : CK_BAD;
                    CK_F1:   ck = (c == B_F) ? CK_F2 : CK_BAD;
                    CK_F2:   ck = CK_BAD;
                    default: ;
                endcase
                if (c == B_COMMA) comma_seen = 1'b1;
                step_number(a_phase, a_mag, c);
                if (b_phase == NP_IDLE) begin
                    if (c == B_COMMA) b_phase = NP_WS;
                end else step_number(b_phase, b_mag, c);
                return;
            end

            // newline closes the frame
            ck_ok     = (ck == CK_F2);
            res.level = 2'd0;
            case (ftype)
                FT_SPEED:   res.kind = KIND_SPEED;
                FT_MONITOR: res.kind = KIND_MONITOR;
                default:    res.kind = KIND_MANUAL;
            endcase
            if (flen > ucfp_pkg::MAX_FRAME) begin
                res.status = ST_TOO_LONG;
            end else if (ftype == FT_SPEED) begin
                if (!comma_seen) begin
                    res.status = ST_NO_COMMA;
                end else if (!ck_ok) begin
                    res.status = ST_BAD_CHECK;
                    right_held = 0;
                    left_held  = 0;
                end else if (a_mag >= order_limit || b_mag >= order_limit) begin
                    res.status = ST_RANGE;
                    right_held = 0;
                    left_held  = 0;
                end else begin
                    res.status = ST_OK;
                    right_held = signed_order(a_phase, a_mag);
                    left_held  = signed_order(b_phase, b_mag);
                end
            end else if (ftype == FT_MONITOR) begin
                if (!ck_ok) begin
                    res.status = ST_BAD_CHECK;
                end else begin
                    res.status = ST_OK;
                    v = signed_order(a_phase, a_mag);
                    if (v >= 0 && v <= 3) res.level = v[1:0];
                end
            end else begin
                if (!comma_seen) res.status = ST_NO_COMMA;
                else if (!ck_ok) res.status = ST_BAD_CHECK;
                else res.status = ST_OK;
            end
            res.right_order = right_held[8:0];
            res.left_order  = left_held[8:0];
            expected_frames.push_back(res);
            predicted_total++;
            open_frame(FT_HUNT);
            flen = 0;
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (expected_frames.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"%0t: result with none expected: kind %0d status %0d",
                              " right %0d left %0d level %0d"},
                             $time, got.kind, got.status, $signed(got.right_order),
                             $signed(got.left_order), got.level);
                return;
            end
            want = expected_frames.pop_front();
            if (got.kind !== want.kind || got.status !== want.status ||
                got.right_order !== want.right_order || got.left_order !== want.left_order ||
                got.level !== want.level) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display({"%0t: mismatch, expected kind %0d status %0d",
                              " right %0d left %0d level %0d"},
                             $time, want.kind, want.status, $signed(want.right_order),
                             $signed(want.left_order), want.level);
                    $display({"%0t:           actual kind %0d status %0d",
                              " right %0d left %0d level %0d"},
                             $time, got.kind, got.status, $signed(got.right_order),
                             $signed(got.left_order), got.level);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_frames.size();
        endfunction
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [7:0]        cfg_wr_data = 8'd0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [7:0]        s_rx_byte   = 8'd0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [1:0]        m_frame_kind;
    logic [2:0]        m_status;
    logic signed [8:0] m_right_order;
    logic signed [8:0] m_left_order;
    logic [1:0]        m_verbose_level;

    frame_scoreboard sb;
    int unsigned     tx_idle_pct   = 0;
    int unsigned     rx_idle_pct   = 0;
    int unsigned     hold_off_left = 0;
    int unsigned     bytes_sent    = 0;
    logic [7:0]      frame_buf[$];

    uart_command_frame_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_kind    (m_frame_kind),
        .m_status        (m_status),
        .m_right_order   (m_right_order),
        .m_left_order    (m_left_order),
        .m_verbose_level (m_verbose_level)
    );

    always #2 aclk = ~aclk;

    // result side ready, with random stalls and a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                m_ready <= 1'b0;
                hold_off_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // check each accepted result item
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_frame_kind, m_status, m_right_order, m_left_order,
                             m_verbose_level});
    end

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("uart_command_frame_parser_tb: done, errors");
        $finish;
    end

    // offer one byte, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // send the built frame, with an occasional zero byte slipped in
    task automatic send_frame_buf();
        foreach (frame_buf[i]) begin
            if ($urandom_range(31) == 0) send_byte(8'h00);
            send_byte(frame_buf[i]);
        end
    endtask

    // stop offering and wait until every result has come, then let the block settle
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.order_limit = v;
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
    endfunction

    // number text: optional whitespace and sign, digits that may overflow
    function automatic void append_number(int unsigned top);
        logic [7:0]  b;
        int unsigned mag;
        int unsigned pick;
        pick = $urandom_range(7);
        b = 8'($urandom_range(9, 13));
        if (pick == 0) frame_buf.push_back(B_SPACE);
        else if (pick == 1) frame_buf.push_back(b);
        pick = $urandom_range(5);
        if (pick == 0) frame_buf.push_back(B_PLUS);
        else if (pick <= 2) frame_buf.push_back(B_MINUS);
        if ($urandom_range(15) == 0) return;
        if ($urandom_range(7) == 0) frame_buf.push_back(B_DIGIT0);
        mag = ($urandom_range(9) == 0) ? $urandom_range(99999) : $urandom_range(top);
        push_text($sformatf("%0d", mag));
    endfunction

    // checksum tail, mostly good, sometimes broken or missing the newline
    function automatic void append_tail();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        case ($urandom_range(15))
            0: push_text("*F\n");
            1: push_text("*FG\n");
            2: push_text("\n");
            3: push_text("*FF*\n");
            4: push_text("*ff\n");
            5: begin
                push_text("*FF");
                frame_buf.push_back(b);
                frame_buf.push_back(B_NL);
            end
            6: push_text("*FF");
            default: push_text("*FF\n");
        endcase
    endfunction

    task automatic send_random_frame();
        logic [7:0]  b;
        int unsigned n;
        frame_buf.delete();
        if ($urandom_range(99) < 12) begin
            // line noise, may hold start bytes and newlines
            n = $urandom_range(1, 6);
            repeat (n) begin
                b = 8'($urandom_range(255));
                frame_buf.push_back(b);
            end
        end else begin
            case ($urandom_range(2))
                0: begin
                    frame_buf.push_back(B_SPEED);
                    append_number(300);
                    if ($urandom_range(9) != 0) frame_buf.push_back(B_COMMA);
                    append_number(300);
                    if ($urandom_range(7) == 0) begin
                        b = 8'($urandom_range(1, 255));
                        frame_buf.push_back(b);
                    end
                end
                1: begin
                    frame_buf.push_back(B_MONITOR);
                    append_number(5);
                end
                default: begin
                    frame_buf.push_back(B_MANUAL);
                    n = $urandom_range(0, 5);
                    repeat (n) begin
                        b = 8'($urandom_range(32, 126));
                        frame_buf.push_back(b);
                    end
                    if ($urandom_range(9) < 7) frame_buf.push_back(B_COMMA);
                    n = $urandom_range(0, 3);
                    repeat (n) begin
                        b = 8'($urandom_range(32, 126));
                        frame_buf.push_back(b);
                    end
                end
            endcase
            append_tail();
        end
        send_frame_buf();
    endtask

    task automatic run_random_phase(input int unsigned byte_goal,
                                    input int unsigned frame_goal);
        int unsigned start_bytes;
        int unsigned start_frames;
        start_bytes  = bytes_sent;
        start_frames = sb.predicted_total;
        while (bytes_sent - start_bytes < byte_goal ||
               sb.predicted_total - start_frames < frame_goal)
            send_random_frame();
    endtask

    // speed frame of a given total length, padded before the checksum
    task automatic send_padded_speed(input int unsigned total_len);
        frame_buf.delete();
        push_text("$1,2");
        repeat (total_len - 8) frame_buf.push_back(8'h61);
        push_text("*FF\n");
        send_frame_buf();
    endtask

    // main sequence
    initial begin
        logic [7:0] b;
        sb = new();
        tx_idle_pct = 9;
        rx_idle_pct = 88;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_limit(8'd255);

        // directed frames
        send_text("xyz\n*FF\n");
        send_text("$12,-34*FF\n");
        send_text("$ +254 , -254*FF\n");
        send_text("$255,0*FF\n");
        send_text("$1,2*FG\n");
        send_text("$1 2*FF\n");
        send_text("$3,4\n");
        send_text("$99999,-99999*FF\n");
        send_text("$-,+*FF\n");
        send_text("$5,$6*FF\n");
        send_text("$1,1*FF*\n");
        send_text("$*FF,1\n");
        send_byte(8'h00);
        send_text("$7");
        send_byte(8'h00);
        send_text(",8*FF\n");
        send_text("$9,");
        send_byte(8'hFF);
        send_text("1*FF\n");
        send_text("$");
        send_byte(8'h0B);
        send_byte(B_CR);
        send_text("5,\t6*FF\n");
        send_text("&2*FF\n");
        send_text("&+3*FF\n");
        send_text("&7*FF\n");
        send_text("&-1*FF\n");
        send_text("&3*F\n");
        send_text("#1,2*FF\n");
        send_text("#12*FF\n");
        send_text("#,*FX\n");
        send_text("#&$,*FF\n");
        drain_results();

        // smallest limits
        write_limit(8'd1);
        send_text("$-0,+0*FF\n$0,1*FF\n$3,4*FF\n");
        drain_results();
        write_limit(8'd0);
        send_text("$0,0*FF\n");
        drain_results();

        // random, slow receiver
        write_limit(8'd100);
        run_random_phase(40, 4);
        drain_results();

        // random, slow sender
        tx_idle_pct = 88;
        rx_idle_pct = 9;
        b = 8'($urandom_range(1, 255));
        write_limit(b);
        run_random_phase(40, 4);
        drain_results();

        // receiver holds off while bytes keep coming, so the block backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_limit(8'd200);
        hold_off_left = 400;
        repeat (12) send_text("#,*FF\n");
        send_text("$-199,199*FF\n");
        drain_results();

        // frames at and just over the length bound
        write_limit(8'd255);
        send_padded_speed(ucfp_pkg::MAX_FRAME);
        send_padded_speed(ucfp_pkg::MAX_FRAME + 1);
        drain_results();

        // random, no idling
        run_random_phase(40, 4);
        drain_results();

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("uart_command_frame_parser_tb: done, clean");
        else
            $display("uart_command_frame_parser_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ucfp_pkg.sv
rtl/ucfp_front.sv
rtl/ucfp_queue.sv
rtl/ucfp_back.sv
rtl/uart_command_frame_parser.sv
tb/sv/uart_command_frame_parser_tb.sv
